// ----- hdl/cfl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_pkg: shared constants for the complex 49-tap FIR low-pass
// Default widths, tap counts and the Q0.24 master coefficient table, with the
// function that rounds a master coefficient to the working coefficient width.
// ----------------------------------------------------------------------------
package cfl_pkg;

	localparam int TAPS_DEF     = 49;
	localparam int MAX_TAPS     = 63;
	localparam int SAMPLE_W_DEF = 16;
	localparam int COEF_W_DEF   = 18;
	localparam int MASTER_FRAC  = 24;
	localparam int MASTER_W     = 20;
	// Headroom above one product for the sum over up to 63 taps.
	localparam int ACC_GUARD    = 6;

	localparam logic [MASTER_W-1:0] COEF_Q24 [MAX_TAPS] = '{
		20'd51620,  20'd54159,  20'd61734,  20'd74214,  20'd91387,  20'd112958,
		20'd138558, 20'd167749, 20'd200033, 20'd234856, 20'd271622, 20'd309704,
		20'd348448, 20'd387193, 20'd425274, 20'd462042, 20'd496865, 20'd529150,
		20'd558346, 20'd583943, 20'd605515, 20'd622688, 20'd635169, 20'd642744,
		20'd645284,
		20'd642744, 20'd635169, 20'd622688, 20'd605515, 20'd583943, 20'd558346,
		20'd529150, 20'd496865, 20'd462042, 20'd425274, 20'd387193, 20'd348448,
		20'd309704, 20'd271622, 20'd234856, 20'd200033, 20'd167749, 20'd138558,
		20'd112958, 20'd91387,  20'd74214,  20'd61734,  20'd54159,  20'd51620,
		20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0,
		20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0
	};

	// Coefficient k at a width of cw bits, Q0.(cw-1), rounded half up.
	function automatic logic [MASTER_FRAC:0] coef_at(input logic [5:0] k, input int cw);
		int                   s;
		logic [MASTER_FRAC:0] v;
		s = MASTER_FRAC - (cw - 1);
		v = {{(MASTER_FRAC + 1 - MASTER_W){1'b0}}, COEF_Q24[k]};
		if (s <= 0) begin
			return v;
		end
		return (v + ((MASTER_FRAC + 1)'(1) << (s - 1))) >> s;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cfl_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_in_if: input sample channel
// One complex Q1.15 sample per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfl_in_if import cfl_pkg::*; #(
	parameter int W = SAMPLE_W_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample_i;
	logic signed [W-1:0] sample_q;

	modport source (output valid, output sample_i, output sample_q, input ready);
	modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface
`default_nettype wire

// ----- hdl/cfl_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_out_if: filtered sample channel
// One filtered complex Q1.15 sample per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfl_out_if import cfl_pkg::*; #(
	parameter int W = SAMPLE_W_DEF
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] filtered_i;
	logic signed [W-1:0] filtered_q;

	modport source (output valid, output filtered_i, output filtered_q, input ready);
	modport sink   (input valid, input filtered_i, input filtered_q, output ready);
endinterface
`default_nettype wire

// ----- hdl/complex_fir_lowpass_49tap_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fir_lowpass_49tap_top: complex 49-tap FIR low-pass
// Filters the I and Q streams through identical symmetric low-pass FIRs with
// fixed Q0.17 coefficients, rounding and saturating back to Q1.15.
// ----------------------------------------------------------------------------
//
//   channel   | direction | beat contents
//   ----------+-----------+-------------------------------------------
//   samples   | in        | sample_i, sample_q  (signed Q1.15)
//   results   | out       | filtered_i, filtered_q (signed Q1.15)
//
// One beat in gives one beat out, in the cycle after acceptance; a new
// sample can be taken every cycle while results is not stalled, set by
// the single multiply-add per tap cell. Reset loads every partial sum
// with the rounding offset, so the filter starts with an all-zero history.
// The output register holds a finished sample while results is stalled;
// samples is then held off, and the tap chain advances only on accepted
// beats, so no stall pattern changes the filtered values.
// Each channel is a transposed-form FIR: TAPS-1 cells, each with one
// multiplier and one adder, pass partial sums toward the output stage.
// The rounding offset enters at the far end of the chain, so the output
// stage only adds the newest tap, drops the fraction and saturates.
// ----------------------------------------------------------------------------
module complex_fir_lowpass_49tap_top import cfl_pkg::*; #(
	parameter int TAPS         = TAPS_DEF,
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
	parameter int COEF_WIDTH   = COEF_W_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cfl_in_if.sink    samples,
	cfl_out_if.source results
);
	// Accumulator width: one product plus headroom for the tap sum.
	localparam int AW = SAMPLE_WIDTH + COEF_WIDTH + ACC_GUARD;

	logic in_acc;
	logic out_vld_q;

	// Take a new beat whenever the output register is empty or being emptied.
	assign samples.ready = !out_vld_q || results.ready;
	assign in_acc        = samples.valid && samples.ready;
	assign results.valid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_acc) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// In-phase channel.
	cfl_channel #(
		.TAPS (TAPS),
		.SW   (SAMPLE_WIDTH),
		.CW   (COEF_WIDTH),
		.AW   (AW)
	) u_chan_i (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (in_acc),
		.x      (samples.sample_i),
		.y_q    (results.filtered_i)
	);

	// Quadrature channel.
	cfl_channel #(
		.TAPS (TAPS),
		.SW   (SAMPLE_WIDTH),
		.CW   (COEF_WIDTH),
		.AW   (AW)
	) u_chan_q (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (in_acc),
		.x      (samples.sample_q),
		.y_q    (results.filtered_q)
	);

	// An accepted sample always shows up as a result in the next cycle.
	a_acc_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_vld_q)
		else $error("accepted sample produced no result");

	// A result that is waiting must block further input.
	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !results.ready) |-> !samples.ready)
		else $error("input taken while a result was stalled");

	// A result disappears only after it was handed over.
	a_result_not_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_vld_q) |-> $past(results.ready))
		else $error("result dropped without a handshake");
endmodule
`default_nettype wire

// ----- hdl/cfl_tap_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_tap_cell: one tap of the transposed-form FIR
// Multiplies the broadcast sample by its fixed coefficient, adds the partial
// sum of its upstream neighbor and holds the result for the next beat.
// ----------------------------------------------------------------------------
module cfl_tap_cell import cfl_pkg::*; #(
	parameter int                SW   = SAMPLE_W_DEF,
	parameter int                CW   = COEF_W_DEF,
	parameter int                AW   = SAMPLE_W_DEF + COEF_W_DEF + ACC_GUARD,
	parameter logic [CW-1:0]     COEF = '0,
	parameter logic [AW-1:0]     RST  = '0
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic signed [SW-1:0] x,
	input  wire logic signed [AW-1:0] p_in,
	output logic signed [AW-1:0]      p_q
);
	localparam logic signed [CW-1:0] COEF_S = COEF;

	logic signed [SW+CW-1:0] prod;
	logic signed [AW-1:0]    sum;

	assign prod = x * COEF_S;
	assign sum  = AW'(prod) + p_in;

	// The reset value carries the rounding offset, so an empty line reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= $signed(RST);
		end else if (en) begin
			p_q <= sum;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cfl_out_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_out_stage: newest tap, rounding and saturation
// Adds the newest sample's product to the chain sum, drops the coefficient
// fraction with floor and clamps the result into the sample range.
// ----------------------------------------------------------------------------
module cfl_out_stage import cfl_pkg::*; #(
	parameter int            SW   = SAMPLE_W_DEF,
	parameter int            CW   = COEF_W_DEF,
	parameter int            AW   = SAMPLE_W_DEF + COEF_W_DEF + ACC_GUARD,
	parameter logic [CW-1:0] COEF = '0
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [SW-1:0] x,
	input  wire logic signed [AW-1:0] p_in,
	output logic signed [SW-1:0]      y_q
);
	localparam int                   RW     = AW - CW + 1;
	localparam logic signed [CW-1:0] COEF_S = COEF;
	localparam logic signed [RW-1:0] HI     = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [RW-1:0] LO     = {{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}};

	logic signed [SW+CW-1:0] prod;
	logic signed [AW-1:0]    sum;
	logic signed [RW-1:0]    r;
	logic signed [SW-1:0]    y_sat;

	assign prod = x * COEF_S;
	assign sum  = AW'(prod) + p_in;
	assign r    = sum[AW-1:CW-1];

	always_comb begin
		if (r > HI) begin
			y_sat = HI[SW-1:0];
		end else if (r < LO) begin
			y_sat = LO[SW-1:0];
		end else begin
			y_sat = r[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_q <= y_sat;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/cfl_channel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cfl_channel: one real FIR channel
// A row of tap cells in transposed form feeding the output stage.
// ----------------------------------------------------------------------------
module cfl_channel import cfl_pkg::*; #(
	parameter int TAPS = TAPS_DEF,
	parameter int SW   = SAMPLE_W_DEF,
	parameter int CW   = COEF_W_DEF,
	parameter int AW   = SAMPLE_W_DEF + COEF_W_DEF + ACC_GUARD
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic signed [SW-1:0] x,
	output logic signed [SW-1:0]      y_q
);
	// Half an output LSB, injected at the far end of the chain.
	localparam logic [AW-1:0] RND = AW'(1) << (CW - 2);

	logic signed [AW-1:0] part [1:TAPS];

	assign part[TAPS] = $signed(RND);

	for (genvar k = 1; k < TAPS; k++) begin : g_tap
		cfl_tap_cell #(
			.SW   (SW),
			.CW   (CW),
			.AW   (AW),
			.COEF (CW'(coef_at(6'(k), CW))),
			.RST  (RND)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.x      (x),
			.p_in   (part[k+1]),
			.p_q    (part[k])
		);
	end

	cfl_out_stage #(
		.SW   (SW),
		.CW   (CW),
		.AW   (AW),
		.COEF (CW'(coef_at(6'(0), CW)))
	) u_out (
		.clk  (clk),
		.en   (en),
		.x    (x),
		.p_in (part[1]),
		.y_q  (y_q)
	);
endmodule
`default_nettype wire

// ----- test/complex_fir_lowpass_49tap_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_fir_lowpass_49tap_top_tb: self-checking bench for the complex FIR
// Streams I/Q samples into the filter through the sample channel and checks
// every filtered beat against a bit-exact fixed-point copy of both FIRs.
// ----------------------------------------------------------------------------
module complex_fir_lowpass_49tap_top_tb;
	import cfl_pkg::*;

	localparam int SW           = SAMPLE_W_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;

	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

	// Shapes of random sample runs. Full-scale runs are longer than the
	// filter so that the output settles at the rails and saturates.
	typedef enum int {
		SEG_RANDOM,
		SEG_FULL_SCALE,
		SEG_ALTERNATE,
		SEG_SMALL,
		SEG_SPARSE
	} seg_kind_t;

	// One input beat plus the handshake pressure that applies while it is sent.
	typedef struct {
		logic signed [SW-1:0] i;
		logic signed [SW-1:0] q;
		int                   idle_pct;
		int                   stall_pct;
	} sample_beat_t;

	typedef struct packed {
		logic signed [SW-1:0] fi;
		logic signed [SW-1:0] fq;
	} filtered_t;

	logic clk;
	logic arst_n;

	cfl_in_if  #(.W(SW)) samples ();
	cfl_out_if #(.W(SW)) results ();

	complex_fir_lowpass_49tap_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	// Beats waiting to be driven, and filtered samples owed by the block.
	sample_beat_t samples_to_send [$];
	filtered_t    filtered_owed [$];

	// Our own copy of both delay lines (newest first) and of the Q0.17 taps.
	logic signed [SW-1:0] delay_line [2][TAPS_DEF-1];
	longint               tap_coef [TAPS_DEF];

	int stall_pct   = 0;
	int error_count = 0;
	int cycle_count = 0;

	initial begin : clock_gen
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		error_count++;
	endtask

	// Round the Q0.24 master table to the working coefficient width, half up.
	function automatic void build_taps();
		int     s;
		int     k;
		longint v;
		s = MASTER_FRAC - (COEF_W_DEF - 1);
		for (k = 0; k < TAPS_DEF; k++) begin
			v = longint'(COEF_Q24[k]);
			if (s > 0) begin
				v = (v + (longint'(1) << (s - 1))) >> s;
			end
			tap_coef[k] = v;
		end
	endfunction

	// Exact multiply-accumulate over the current sample and the history, then the
	// history shifts by one. The sum is rounded half toward plus infinity to
	// Q1.15 and clamped to the sample range.
	function automatic logic signed [SW-1:0] filter_channel(input int ch,
			input logic signed [SW-1:0] x);
		longint acc;
		longint r;
		int     k;
		acc = tap_coef[0] * longint'(x);
		for (k = 1; k < TAPS_DEF; k++) begin
			acc += tap_coef[k] * longint'(delay_line[ch][k-1]);
		end
		for (k = TAPS_DEF - 2; k >= 1; k--) begin
			delay_line[ch][k] = delay_line[ch][k-1];
		end
		delay_line[ch][0] = x;
		r = (acc + (longint'(1) << (COEF_W_DEF - 2))) >>> (COEF_W_DEF - 1);
		if (r > longint'(S_MAX)) begin
			r = longint'(S_MAX);
		end
		if (r < longint'(S_MIN)) begin
			r = longint'(S_MIN);
		end
		return r[SW-1:0];
	endfunction

	function automatic filtered_t filter_sample(input logic signed [SW-1:0] xi,
			input logic signed [SW-1:0] xq);
		filtered_t f;
		f.fi = filter_channel(0, xi);
		f.fq = filter_channel(1, xq);
		return f;
	endfunction

	function automatic void queue_beat(input logic signed [SW-1:0] i,
			input logic signed [SW-1:0] q, input int idle, input int stall);
		sample_beat_t b;
		b.i         = i;
		b.q         = q;
		b.idle_pct  = idle;
		b.stall_pct = stall;
		samples_to_send.push_back(b);
	endfunction

	// Directed opening: impulses at both rails, then the rails and a few
	// bit patterns on each channel, all at full rate.
	function automatic void queue_directed();
		int k;
		queue_beat(S_MAX, S_MIN, 0, 0);
		for (k = 0; k < 6; k++) begin
			queue_beat('0, '0, 0, 0);
		end
		queue_beat(S_MIN, S_MAX, 0, 0);
		queue_beat('0, '0, 0, 0);
		for (k = 0; k < 4; k++) begin
			queue_beat(S_MAX, S_MAX, 0, 0);
		end
		for (k = 0; k < 4; k++) begin
			queue_beat(S_MIN, S_MIN, 0, 0);
		end
		queue_beat(16'sh0001, -16'sh0001, 0, 0);
		queue_beat(-16'sh0001, 16'sh0001, 0, 0);
		queue_beat(16'sh5555, 16'shAAAA, 0, 0);
		queue_beat(16'shAAAA, 16'sh5555, 0, 0);
		queue_beat(S_MAX, S_MIN, 0, 0);
		queue_beat(S_MIN, S_MAX, 0, 0);
		queue_beat(16'sh0100, -16'sh7FFF, 0, 0);
	endfunction

	// Random runs of mixed shapes until about n beats have been queued.
	function automatic void queue_random(input int n, input int idle, input int stall);
		int                   count;
		int                   len;
		int                   k;
		int                   pick;
		seg_kind_t            kind;
		logic signed [SW-1:0] hold_i;
		logic signed [SW-1:0] hold_q;
		logic signed [SW-1:0] xi;
		logic signed [SW-1:0] xq;
		count = 0;
		while (count < n) begin
			pick = $urandom_range(9);
			if (pick <= 3) begin
				kind = SEG_RANDOM;
			end else if (pick <= 5) begin
				kind = SEG_FULL_SCALE;
			end else if (pick == 6) begin
				kind = SEG_ALTERNATE;
			end else if (pick <= 8) begin
				kind = SEG_SMALL;
			end else begin
				kind = SEG_SPARSE;
			end
			hold_i = $urandom_range(1) ? S_MAX : S_MIN;
			hold_q = $urandom_range(1) ? S_MAX : S_MIN;
			len    = (kind == SEG_FULL_SCALE) ? $urandom_range(70, 50) : $urandom_range(30, 4);
			for (k = 0; k < len; k++) begin
				case (kind)
					SEG_RANDOM: begin
						xi = SW'($urandom);
						xq = SW'($urandom);
					end
					SEG_FULL_SCALE: begin
						xi = hold_i;
						xq = hold_q;
					end
					SEG_ALTERNATE: begin
						xi = k[0] ? S_MAX : S_MIN;
						xq = k[0] ? S_MIN : S_MAX;
					end
					SEG_SMALL: begin
						xi = SW'($urandom_range(511)) - SW'(256);
						xq = SW'($urandom_range(511)) - SW'(256);
					end
					default: begin
						xi = ($urandom_range(7) == 0) ? SW'($urandom) : '0;
						xq = ($urandom_range(7) == 0) ? SW'($urandom) : '0;
					end
				endcase
				queue_beat(xi, xq, idle, stall);
			end
			count += len;
		end
	endfunction

	// Sample driver. A beat is accepted at the edge where valid and ready are
	// both high; the filtered sample it owes is predicted right there, from the
	// values the block itself captures. A new beat is presented only when the
	// channel is empty or the current one is being taken, so valid is assigned
	// once per edge and a held beat never changes under the block.
	always @(posedge clk or negedge arst_n) begin : drive_samples
		sample_beat_t b;
		if (!arst_n) begin
			samples.valid    <= 1'b0;
			samples.sample_i <= '0;
			samples.sample_q <= '0;
		end else begin
			if (samples.valid && samples.ready) begin
				filtered_owed.push_back(filter_sample(samples.sample_i, samples.sample_q));
			end
			if (!samples.valid || samples.ready) begin
				if (samples_to_send.size() != 0
						&& $urandom_range(99) >= samples_to_send[0].idle_pct) begin
					b = samples_to_send.pop_front();
					samples.valid    <= 1'b1;
					samples.sample_i <= b.i;
					samples.sample_q <= b.q;
					stall_pct        = b.stall_pct;
				end else begin
					samples.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor. Every accepted filtered beat is matched against the oldest
	// owed sample, field by field. Ready is redrawn each cycle from the stall
	// rate of the phase currently being sent.
	always @(posedge clk or negedge arst_n) begin : check_results
		filtered_t want;
		if (!arst_n) begin
			results.ready <= 1'b0;
		end else begin
			if (results.valid && results.ready) begin
				if (filtered_owed.size() == 0) begin
					report_mismatch($sformatf("filtered beat I=%0d Q=%0d with nothing owed",
						results.filtered_i, results.filtered_q));
				end else begin
					want = filtered_owed.pop_front();
					if (results.filtered_i !== want.fi) begin
						report_mismatch($sformatf("filtered_i got %0d want %0d",
							results.filtered_i, want.fi));
					end
					if (results.filtered_q !== want.fq) begin
						report_mismatch($sformatf("filtered_q got %0d want %0d",
							results.filtered_q, want.fq));
					end
				end
			end
			results.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog: a hang anywhere in the block ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("complex_fir_lowpass_49tap_top_tb: done, errors");
			$finish;
		end
	end

	initial begin : run_test
		int ch;
		int k;
		arst_n = 1'b0;
		for (ch = 0; ch < 2; ch++) begin
			for (k = 0; k < TAPS_DEF - 1; k++) begin
				delay_line[ch][k] = '0;
			end
		end
		build_taps();

		// Pressure phases: full rate, a bursty sender, a slow receiver, both
		// moderately busy, and a final stretch at full rate again.
		queue_directed();
		queue_random(200, 0, 0);
		queue_random(200, 65, 0);
		queue_random(200, 0, 65);
		queue_random(250, 31, 31);
		queue_random(175, 0, 0);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for the last beat to be taken and every owed sample to come back,
		// then run on for DRAIN_CYCLES so the output stage can show any extra beat.
		do begin
			@(posedge clk);
		end while (samples_to_send.size() != 0 || samples.valid || filtered_owed.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("complex_fir_lowpass_49tap_top_tb: done, clean");
		end else begin
			$display("complex_fir_lowpass_49tap_top_tb: done, errors");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/cfl_pkg.sv
hdl/cfl_in_if.sv
hdl/cfl_out_if.sv
hdl/cfl_tap_cell.sv
hdl/cfl_out_stage.sv
hdl/cfl_channel.sv
hdl/complex_fir_lowpass_49tap_top.sv
test/complex_fir_lowpass_49tap_top_tb.sv
